@@ rtl/button_encoder_event_qualifier_top_assert.svh @@
// assertion macros used by the top-level rtl file
`ifndef BUTTON_ENCODER_EVENT_QUALIFIER_TOP_ASSERT_SVH
`define BUTTON_ENCODER_EVENT_QUALIFIER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication, disabled while in reset
`define BEQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("beq assertion failed");

// next-cycle implication, disabled while in reset
`define BEQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("beq assertion failed");

`else

`define BEQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define BEQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/beq_pkg.sv @@
`default_nettype none

package beq_pkg;

    // event kinds
    localparam logic [1:0] KIND_WAKE   = 2'd0;
    localparam logic [1:0] KIND_SHORT  = 2'd1;
    localparam logic [1:0] KIND_LONG   = 2'd2;
    localparam logic [1:0] KIND_MOTION = 2'd3;

    // request commands
    localparam logic CMD_POLL  = 1'b0;
    localparam logic CMD_BEGIN = 1'b1;

    // configuration register indexes
    localparam logic [1:0] CFG_DEBOUNCE  = 2'd0;
    localparam logic [1:0] CFG_LONG      = 2'd1;
    localparam logic [1:0] CFG_INTERVAL  = 2'd2;
    localparam logic [1:0] CFG_MAX_EVENT = 2'd3;

    // result queue sizing
    localparam int unsigned MAX_RESULTS = 2;
    localparam int unsigned EVQ_DEPTH   = 4;
    localparam int unsigned EVQ_PTR_W   = $clog2(EVQ_DEPTH);
    localparam int unsigned EVQ_CNT_W   = $clog2(EVQ_DEPTH + 1);
    localparam logic [EVQ_CNT_W-1:0] EVQ_ACCEPT_MAX = EVQ_CNT_W'(EVQ_DEPTH - MAX_RESULTS);

    // one result
    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] delta;
        logic               last;
    } t_event;

    // side fields of one request moving down the pipe
    typedef struct packed {
        logic        cmd;
        logic [31:0] now;
        logic        level;
    } t_item;

endpackage

`default_nettype wire

@@ rtl/button_encoder_event_qualifier_top.sv @@
// channel   | dir | signals                         | contents
// ----------+-----+---------------------------------+-----------------------------------------
// request   | in  | i_s_tvalid/o_s_tready/tdata/tuser| tdata: now_ms, button_level,
//           |     |                                 | encoder_count; tuser: command
// event     | out | o_m_tvalid/i_m_tready/tdata/    | tdata: step_delta; tuser: event_kind;
//           |     | tlast/tuser                     | tlast: last_event
// config    | in  | i_cfg_we/i_cfg_index/i_cfg_data | register write, no read-back
//
// one request is taken per cycle while o_s_tready is high; each passes three
// pipe registers (the divide by ticks per step is a reciprocal multiply plus
// one correction), then the debounce and encoder state step, and its events
// are written into the event queue.
// the four-entry event queue accepts a request while it holds two or fewer
// events; requests yielding two events drain at one event per cycle while i_m_tready is high.
// synchronous active-low reset restores register defaults and clears state.
`default_nettype none

`include "button_encoder_event_qualifier_top_assert.svh"

module button_encoder_event_qualifier_top
    import beq_pkg::*;
#(
    parameter int TICKS_PER_STEP = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request channel
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [71:0] i_s_tdata,   // now_ms[31:0], button_level[32], encoder_count[64:33]
    input  wire logic        i_s_tuser,   // command[0]
    // event channel
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [15:0]      o_m_tdata,   // step_delta[15:0]
    output logic             o_m_tlast,
    output logic [1:0]       o_m_tuser,   // event_kind[1:0]
    // configuration
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    // configuration registers
    logic [15:0] r_debounce_ms;
    logic [15:0] r_long_press_ms;
    logic [15:0] r_read_interval_ms;
    logic [1:0]  r_max_events;

    // qualifier state
    logic        r_prev_raw_pressed;
    logic [31:0] r_raw_change_time;
    logic        r_stable_pressed;
    logic [31:0] r_press_start_time;
    logic        r_press_reported;
    logic        r_long_reported;
    logic [31:0] r_enc_baseline;
    logic [31:0] r_enc_sample_time;
    logic        r_enc_ready;

    // pipe
    t_item       r_pipe [3];
    logic [2:0]  r_vld;

    t_item       w_in_item;
    logic [31:0] w_steps;
    logic        w_adv;
    logic        w_step_fire;
    logic [EVQ_CNT_W-1:0] w_count;
    t_event      w_ev0;
    t_event      w_ev1;
    t_event      w_out_ev;
    logic [1:0]  w_push_cnt;

    // step outputs
    logic        w_raw_pressed;
    logic [31:0] w_change_time;
    logic        w_settled;
    logic        w_ev_wake;
    logic        w_ev_short;
    logic        w_ev_long;
    logic        w_ev_btn;
    logic [1:0]  w_btn_kind;
    logic        w_stable_n;
    logic [31:0] w_press_start_n;
    logic        w_long_mid;
    logic        w_enc_go;
    logic [31:0] w_delta;
    logic        w_ev_motion;
    logic        w_two_allowed;
    logic [1:0]  w_found;

    // request unpacking
    assign w_in_item.cmd   = i_s_tuser;
    assign w_in_item.now   = i_s_tdata[31:0];
    assign w_in_item.level = i_s_tdata[32];

    // the pipe moves when the queue has room for a full set of events
    assign w_adv       = (w_count <= EVQ_ACCEPT_MAX);
    assign o_s_tready  = w_adv;
    assign w_step_fire = w_adv && r_vld[2];

    beq_to_steps #(
        .TICKS_PER_STEP (TICKS_PER_STEP)
    ) u_to_steps (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_count (signed'(i_s_tdata[64:33])),
        .o_steps (w_steps)
    );

    // side fields travel alongside the divider
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_pipe[0] <= w_in_item;
            r_pipe[1] <= r_pipe[0];
            r_pipe[2] <= r_pipe[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[1:0], i_s_tvalid};
        end
    end

    // button debounce and press classification
    always_comb begin
        w_raw_pressed   = !r_pipe[2].level;
        w_change_time   = (w_raw_pressed != r_prev_raw_pressed) ? r_pipe[2].now
                                                                : r_raw_change_time;
        w_settled       = ((r_pipe[2].now - w_change_time) > {16'd0, r_debounce_ms});
        w_ev_wake       = w_settled && (w_raw_pressed != r_stable_pressed) && w_raw_pressed;
        w_ev_short      = w_settled && (w_raw_pressed != r_stable_pressed) && !w_raw_pressed
                          && !r_press_reported && !r_long_reported;
        w_stable_n      = w_settled ? w_raw_pressed : r_stable_pressed;
        w_press_start_n = w_ev_wake ? r_pipe[2].now : r_press_start_time;
        w_long_mid      = w_ev_wake ? 1'b0 : r_long_reported;
        w_ev_long       = w_settled && w_stable_n && !w_long_mid
                          && ((r_pipe[2].now - w_press_start_n) > {16'd0, r_long_press_ms});
        w_ev_btn        = w_ev_wake || w_ev_short || w_ev_long;
        w_btn_kind      = w_ev_wake ? KIND_WAKE : (w_ev_short ? KIND_SHORT : KIND_LONG);
    end

    // encoder sampling
    always_comb begin
        w_enc_go    = r_enc_ready
                      && ((r_pipe[2].now - r_enc_sample_time) >= {16'd0, r_read_interval_ms});
        w_delta     = w_steps - r_enc_baseline;
        w_ev_motion = w_enc_go && (w_delta != 32'd0);
    end

    // event list for the queue
    always_comb begin
        w_two_allowed = (r_max_events != 2'd1);
        w_found       = 2'(w_ev_btn) + 2'(w_ev_motion);
        w_push_cnt    = 2'd0;
        if (w_step_fire && (r_pipe[2].cmd == CMD_POLL) && (r_max_events != 2'd0)) begin
            w_push_cnt = (!w_two_allowed && (w_found == 2'd2)) ? 2'd1 : w_found;
        end
        w_ev0.kind  = w_ev_btn ? w_btn_kind : KIND_MOTION;
        w_ev0.delta = w_ev_btn ? 16'sd0 : signed'(w_delta[15:0]);
        w_ev0.last  = (w_push_cnt == 2'd1);
        w_ev1.kind  = KIND_MOTION;
        w_ev1.delta = signed'(w_delta[15:0]);
        w_ev1.last  = 1'b1;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ms      <= 16'd50;
            r_long_press_ms    <= 16'd1000;
            r_read_interval_ms <= 16'd10;
            r_max_events       <= 2'd2;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DEBOUNCE:  r_debounce_ms      <= i_cfg_data;
                CFG_LONG:      r_long_press_ms    <= i_cfg_data;
                CFG_INTERVAL:  r_read_interval_ms <= i_cfg_data;
                CFG_MAX_EVENT: r_max_events       <= i_cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    // state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_raw_pressed <= 1'b0;
            r_raw_change_time  <= '0;
            r_stable_pressed   <= 1'b0;
            r_press_start_time <= '0;
            r_press_reported   <= 1'b0;
            r_long_reported    <= 1'b0;
            r_enc_baseline     <= '0;
            r_enc_sample_time  <= '0;
            r_enc_ready        <= 1'b0;
        end else if (w_step_fire) begin
            if (r_pipe[2].cmd == CMD_BEGIN) begin
                r_enc_baseline    <= w_steps;
                r_enc_sample_time <= '0;
                r_enc_ready       <= 1'b1;
            end else if (r_max_events != 2'd0) begin
                r_prev_raw_pressed <= w_raw_pressed;
                r_raw_change_time  <= w_change_time;
                r_stable_pressed   <= w_stable_n;
                r_press_start_time <= w_press_start_n;
                if (w_ev_wake) begin
                    r_press_reported <= 1'b0;
                    r_long_reported  <= 1'b0;
                end
                if (w_ev_short) begin
                    r_press_reported <= 1'b1;
                end
                if (w_ev_long) begin
                    r_press_reported <= 1'b1;
                    r_long_reported  <= 1'b1;
                end
                if (w_ev_motion) begin
                    r_enc_baseline <= w_steps;
                end
                if (w_enc_go) begin
                    r_enc_sample_time <= r_pipe[2].now;
                end
            end
        end
    end

    beq_out_fifo u_out_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (w_push_cnt),
        .i_ev0      (w_ev0),
        .i_ev1      (w_ev1),
        .i_ready    (i_m_tready),
        .o_valid    (o_m_tvalid),
        .o_event    (w_out_ev),
        .o_count    (w_count)
    );

    // output packing
    assign o_m_tdata = 16'(w_out_ev.delta);
    assign o_m_tuser = w_out_ev.kind;
    assign o_m_tlast = w_out_ev.last;

    // assertions
    `BEQ_ASSERT_IMPL(a_begin_silent, i_clk, i_rst_n,
        w_step_fire && (r_pipe[2].cmd == CMD_BEGIN), w_push_cnt == 2'd0)
    `BEQ_ASSERT_NEXT(a_begin_arms_encoder, i_clk, i_rst_n,
        w_step_fire && (r_pipe[2].cmd == CMD_BEGIN), r_enc_ready)
    `BEQ_ASSERT_IMPL(a_press_wakes, i_clk, i_rst_n,
        $rose(r_stable_pressed), $past(w_push_cnt) != 2'd0)
    `BEQ_ASSERT_IMPL(a_long_marks_press, i_clk, i_rst_n,
        $rose(r_long_reported), r_press_reported)

endmodule

`default_nettype wire

@@ rtl/beq_to_steps.sv @@
`default_nettype none

// signed count divided by the ticks per step, truncating toward zero;
// three register stages: magnitude, reciprocal product, corrected quotient
module beq_to_steps #(
    parameter int TICKS_PER_STEP = 4
) (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic signed [31:0] i_count,
    output logic        [31:0]      o_steps
);

    localparam int unsigned SHIFT = 32 + $clog2(TICKS_PER_STEP);
    localparam logic [32:0] RECIP = 33'((65'd1 << SHIFT) / 65'(TICKS_PER_STEP));
    localparam logic [31:0] DIVISOR = 32'(TICKS_PER_STEP);

    logic [31:0] r_mag;
    logic        r_neg;
    logic [64:0] r_prod;
    logic [31:0] r_mag2;
    logic        r_neg2;
    logic [31:0] r_steps;

    logic [31:0] w_abs;
    logic [31:0] w_q0;
    logic [31:0] w_rem;
    logic [31:0] w_q;

    // magnitude of the raw count
    assign w_abs = i_count[31] ? (32'd0 - 32'(i_count)) : 32'(i_count);

    // estimate is the quotient or one below it
    assign w_q0  = 32'(r_prod >> SHIFT);
    assign w_rem = r_mag2 - 32'(w_q0 * DIVISOR);
    assign w_q   = (w_rem >= DIVISOR) ? (w_q0 + 32'd1) : w_q0;

    // stage registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag   <= w_abs;
            r_neg   <= i_count[31];
            r_prod  <= {33'd0, r_mag} * {32'd0, RECIP};
            r_mag2  <= r_mag;
            r_neg2  <= r_neg;
            r_steps <= r_neg2 ? (32'd0 - w_q) : w_q;
        end
    end

    assign o_steps = r_steps;

endmodule

`default_nettype wire

@@ rtl/beq_out_fifo.sv @@
`default_nettype none

// small result queue: up to two writes and one read per cycle
module beq_out_fifo
    import beq_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic [1:0]           i_push_cnt,
    input  wire t_event               i_ev0,
    input  wire t_event               i_ev1,
    input  wire logic                 i_ready,
    output logic                      o_valid,
    output t_event                    o_event,
    output logic [EVQ_CNT_W-1:0]      o_count
);

    t_event                 r_mem [EVQ_DEPTH];
    logic [EVQ_PTR_W-1:0]   r_wr_ptr;
    logic [EVQ_PTR_W-1:0]   r_rd_ptr;
    logic [EVQ_CNT_W-1:0]   r_count;
    logic                   w_pop;

    assign o_valid = (r_count != '0);
    assign w_pop   = o_valid && i_ready;
    assign o_event = r_mem[r_rd_ptr];
    assign o_count = r_count;

    // entry writes
    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_ev0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[r_wr_ptr + EVQ_PTR_W'(1)] <= i_ev1;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + EVQ_PTR_W'(i_push_cnt);
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + EVQ_PTR_W'(1);
            end
            r_count <= r_count + EVQ_CNT_W'(i_push_cnt) - EVQ_CNT_W'(w_pop);
        end
    end

endmodule

`default_nettype wire
